// ----- rtl/core/ipv4lpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ipv4lpm_pkg;

  // Default number of route slots.
  localparam int TABLE_DEPTH = 16;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_MATCH  = 2'd3;

  // One request as held during its scan. The mask is already zero when absent.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              has_mask;
  } req_t;

  // Contents of one route slot.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              has_mask;
  } slot_t;

  // Running best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              has_mask;
  } cand_t;

  // Table update issued when an item completes.
  typedef struct packed {
    logic add_en;
    logic del_en;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipv4lpm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipv4lpm_cell #(
  parameter int DEPTH    = ipv4lpm_pkg::TABLE_DEPTH,
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = $clog2(DEPTH)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire ipv4lpm_pkg::req_t   req,
  input  wire ipv4lpm_pkg::cmd_t   cmd,
  input  wire [IDX_W-1:0]          del_idx,
  input  wire                      below_valid,
  input  wire ipv4lpm_pkg::slot_t  slot_above,
  input  wire ipv4lpm_pkg::cand_t  cand_in,
  input  wire [IDX_W-1:0]          idx_in,
  output ipv4lpm_pkg::slot_t       slot,
  output ipv4lpm_pkg::cand_t       cand_out,
  output logic [IDX_W-1:0]         idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                           valid_r, valid_nxt;
  logic [ipv4lpm_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [ipv4lpm_pkg::ADDR_W-1:0] mask_r, mask_nxt;
  logic                           hm_r, hm_nxt;
  ipv4lpm_pkg::cand_t             cand_r, cand_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;

  logic exact_ok;
  logic match_ok;
  logic take;

  // Compare this slot against the request.
  always_comb begin
    exact_ok = (addr_r == req.addr) &&
               ((req.has_mask && hm_r && (mask_r == req.mask)) ||
                (!req.has_mask && !hm_r));
    match_ok = ((addr_r & mask_r) == (req.addr & mask_r));
    case (req.func)
      ipv4lpm_pkg::FUNC_DELETE,
      ipv4lpm_pkg::FUNC_LOOKUP: begin
        take = valid_r && exact_ok && !cand_in.found;
      end
      ipv4lpm_pkg::FUNC_MATCH: begin
        take = valid_r && match_ok &&
               (hm_r ? (mask_r >= cand_in.mask) : !cand_in.found);
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // Keep the incoming candidate or replace it with this slot.
  always_comb begin
    if (take) begin
      cand_nxt.found    = 1'b1;
      cand_nxt.addr     = addr_r;
      cand_nxt.mask     = mask_r;
      cand_nxt.has_mask = hm_r;
      idx_nxt           = MY_IDX;
    end else begin
      cand_nxt = cand_in;
      idx_nxt  = idx_in;
    end
  end

  // A new entry lands in the first free slot; a delete pulls the newer slots down.
  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    mask_nxt  = mask_r;
    hm_nxt    = hm_r;
    if (cmd.add_en && !valid_r && below_valid) begin
      valid_nxt = 1'b1;
      addr_nxt  = req.addr;
      mask_nxt  = req.mask;
      hm_nxt    = req.has_mask;
    end else if (cmd.del_en && valid_r && (MY_IDX >= del_idx)) begin
      valid_nxt = slot_above.valid;
      addr_nxt  = slot_above.addr;
      mask_nxt  = slot_above.mask;
      hm_nxt    = slot_above.has_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    mask_r <= mask_nxt;
    hm_r   <= hm_nxt;
    cand_r <= cand_nxt;
    idx_r  <= idx_nxt;
  end

  assign slot.valid    = valid_r;
  assign slot.addr     = addr_r;
  assign slot.mask     = mask_r;
  assign slot.has_mask = hm_r;
  assign cand_out      = cand_r;
  assign idx_out       = idx_r;

endmodule

`default_nettype wire

// ----- rtl/core/ipv4_route_table_lpm_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// An add goes from capture straight to completion; delete, exact lookup and longest
// match first scan the row, the candidate passing one cell per cycle, then complete.
// One item at a time; an item completes only when the output register is free.
// A result waiting in the output register does not block acceptance of the next item.
// Reset (synchronous, active low) empties the table and returns the control to idle.
module ipv4_route_table_lpm_top #(
  parameter int DEPTH = ipv4lpm_pkg::TABLE_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [ipv4lpm_pkg::FUNC_W-1:0]       in_func,
  input  wire [ipv4lpm_pkg::ADDR_W-1:0]       in_dest_addr,
  input  wire [ipv4lpm_pkg::ADDR_W-1:0]       in_dest_mask,
  input  wire                                 in_mask_given,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                out_found,
  output logic [ipv4lpm_pkg::ADDR_W-1:0]      out_route_addr,
  output logic [ipv4lpm_pkg::ADDR_W-1:0]      out_route_mask,
  output logic                                out_route_has_mask,
  output logic [ipv4lpm_pkg::COUNT_W-1:0]     out_entry_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  ipv4lpm_pkg::req_t  req_r;
  ipv4lpm_pkg::cmd_t  cmd;

  logic out_valid_r, out_valid_nxt;
  logic out_found_r;
  logic [ipv4lpm_pkg::ADDR_W-1:0] out_addr_r;
  logic [ipv4lpm_pkg::ADDR_W-1:0] out_mask_r;
  logic out_hm_r;
  logic [ipv4lpm_pkg::COUNT_W-1:0] out_count_r;

  ipv4lpm_pkg::slot_t slot_q [DEPTH];
  ipv4lpm_pkg::cand_t cand_q [DEPTH];
  logic [IDX_W-1:0]   idx_q  [DEPTH];
  logic [DEPTH-1:0]   valid_vec;

  logic in_accept;
  logic out_free;
  logic commit;
  logic is_add;
  logic full;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_FINISH) && out_free;
  assign is_add    = (req_r.func == ipv4lpm_pkg::FUNC_ADD);
  assign full      = slot_q[DEPTH-1].valid;

  // Row of slot cells; the candidate runs from the newest end toward slot 0.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      ipv4lpm_pkg::slot_t above;
      ipv4lpm_pkg::cand_t cin;
      logic [IDX_W-1:0]   iin;
      logic               below;

      if (gi == DEPTH - 1) begin : g_top
        assign above = '0;
        assign cin   = '0;
        assign iin   = '0;
      end else begin : g_mid
        assign above = slot_q[gi+1];
        assign cin   = cand_q[gi+1];
        assign iin   = idx_q[gi+1];
      end

      if (gi == 0) begin : g_bottom
        assign below = 1'b1;
      end else begin : g_upper
        assign below = slot_q[gi-1].valid;
      end

      ipv4lpm_cell #(
        .DEPTH    (DEPTH),
        .CELL_IDX (gi),
        .IDX_W    (IDX_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_r),
        .cmd         (cmd),
        .del_idx     (idx_q[0]),
        .below_valid (below),
        .slot_above  (above),
        .cand_in     (cin),
        .idx_in      (iin),
        .slot        (slot_q[gi]),
        .cand_out    (cand_q[gi]),
        .idx_out     (idx_q[gi])
      );

      assign valid_vec[gi] = slot_q[gi].valid;
    end
  endgenerate

  // Table update when the item completes.
  always_comb begin
    cmd.add_en = commit && is_add && !full;
    cmd.del_en = commit && (req_r.func == ipv4lpm_pkg::FUNC_DELETE) && cand_q[0].found;
  end

  // Sequencer: capture, scan the row unless the item is an add, then complete into the output register.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_accept) begin
          state_nxt = (in_func == ipv4lpm_pkg::FUNC_ADD) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
          if (cmd.add_en) begin
            used_nxt = used_r + 1'b1;
          end else if (cmd.del_en) begin
            used_nxt = used_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
    end
  end

  // Request capture; an absent mask is stored as zero.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.func     <= in_func;
      req_r.addr     <= in_dest_addr;
      req_r.mask     <= in_mask_given ? in_dest_mask : '0;
      req_r.has_mask <= in_mask_given;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_count_r <= ipv4lpm_pkg::COUNT_W'(used_nxt);
      if (is_add) begin
        out_found_r <= !full;
        out_addr_r  <= full ? '0 : req_r.addr;
        out_mask_r  <= full ? '0 : req_r.mask;
        out_hm_r    <= !full && req_r.has_mask;
      end else begin
        out_found_r <= cand_q[0].found;
        out_addr_r  <= cand_q[0].addr;
        out_mask_r  <= cand_q[0].mask;
        out_hm_r    <= cand_q[0].has_mask;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_route_addr     = out_addr_r;
  assign out_route_mask     = out_mask_r;
  assign out_route_has_mask = out_hm_r;
  assign out_entry_count    = out_count_r;

  // The occupied slots always form a run starting at slot 0.
  a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("route slots not contiguous");

  // The entry counter tracks the occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_vec)) == used_r)
    else $error("entry count disagrees with slot valid bits");

  // A new result only appears after the sequencer completes an item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result produced outside completion");

  // A reported entry without a mask carries a zero mask.
  a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hm_r) |-> (out_mask_r == '0))
    else $error("nonzero mask on unmasked result");

endmodule

`default_nettype wire

// ----- sim/ipv4_route_table_lpm_top_tb.sv -----
`timescale 1ns / 1ps

module ipv4_route_table_lpm_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;

  // One request as driven on the input channel.
  typedef struct packed {
    logic [ipv4lpm_pkg::FUNC_W-1:0] func;
    logic [ipv4lpm_pkg::ADDR_W-1:0] addr;
    logic [ipv4lpm_pkg::ADDR_W-1:0] mask;
    logic                           given;
  } route_req_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic                            found;
    logic [ipv4lpm_pkg::ADDR_W-1:0]  addr;
    logic [ipv4lpm_pkg::ADDR_W-1:0]  mask;
    logic                            has_mask;
    logic [ipv4lpm_pkg::COUNT_W-1:0] count;
  } route_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [ipv4lpm_pkg::FUNC_W-1:0]  in_func = ipv4lpm_pkg::FUNC_ADD;
  logic [ipv4lpm_pkg::ADDR_W-1:0]  in_dest_addr = '0;
  logic [ipv4lpm_pkg::ADDR_W-1:0]  in_dest_mask = '0;
  logic                            in_mask_given = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_found;
  logic [ipv4lpm_pkg::ADDR_W-1:0]  out_route_addr;
  logic [ipv4lpm_pkg::ADDR_W-1:0]  out_route_mask;
  logic                            out_route_has_mask;
  logic [ipv4lpm_pkg::COUNT_W-1:0] out_entry_count;

  // Shadow copy of the route table, oldest entry at index 0.
  logic [ipv4lpm_pkg::ADDR_W-1:0] tbl_addr [ipv4lpm_pkg::TABLE_DEPTH];
  logic [ipv4lpm_pkg::ADDR_W-1:0] tbl_mask [ipv4lpm_pkg::TABLE_DEPTH];
  logic                           tbl_has_mask [ipv4lpm_pkg::TABLE_DEPTH];
  int                             tbl_used = 0;

  route_result_t expected_routes[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            long_hold_cycles = 0;
  bit            in_idle_on = 1'b1;
  bit            out_idle_on = 1'b1;

  ipv4_route_table_lpm_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_dest_addr       (in_dest_addr),
    .in_dest_mask       (in_dest_mask),
    .in_mask_given      (in_mask_given),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_route_addr     (out_route_addr),
    .out_route_mask     (out_route_mask),
    .out_route_has_mask (out_route_has_mask),
    .out_entry_count    (out_entry_count)
  );

  always #1 clk = ~clk;

  // Applies one request to the shadow table and returns the route it reports.
  function automatic route_result_t route_table_apply(input route_req_t req);
    route_result_t                  res;
    logic [ipv4lpm_pkg::ADDR_W-1:0] req_mask;
    logic [ipv4lpm_pkg::ADDR_W-1:0] m;
    logic [ipv4lpm_pkg::ADDR_W-1:0] top_mask;
    int                             hit;
    int                             i;
    res = '0;
    req_mask = req.given ? req.mask : '0;
    hit = -1;
    top_mask = '0;
    if (req.func == ipv4lpm_pkg::FUNC_ADD) begin
      if (tbl_used < ipv4lpm_pkg::TABLE_DEPTH) begin
        tbl_addr[tbl_used] = req.addr;
        tbl_mask[tbl_used] = req_mask;
        tbl_has_mask[tbl_used] = req.given;
        tbl_used++;
        res.found = 1'b1;
        res.addr = req.addr;
        res.mask = req_mask;
        res.has_mask = req.given;
      end
    end else if (req.func == ipv4lpm_pkg::FUNC_MATCH) begin
      // Walk newest to oldest; ties on the mask go to the older entry.
      for (i = tbl_used - 1; i >= 0; i--) begin
        m = tbl_has_mask[i] ? tbl_mask[i] : '0;
        if ((tbl_addr[i] & m) == (req.addr & m)) begin
          if (tbl_has_mask[i]) begin
            if (m >= top_mask) begin
              top_mask = m;
              hit = i;
            end
          end else if (hit < 0) begin
            hit = i;
          end
        end
      end
    end else begin
      // Exact agreement: same address, masks both present and equal or both absent.
      for (i = tbl_used - 1; i >= 0; i--) begin
        if (tbl_addr[i] == req.addr &&
            ((req.given && tbl_has_mask[i] && tbl_mask[i] == req_mask) ||
             (!req.given && !tbl_has_mask[i]))) begin
          hit = i;
          break;
        end
      end
    end
    if (req.func != ipv4lpm_pkg::FUNC_ADD && hit >= 0) begin
      res.found = 1'b1;
      res.addr = tbl_addr[hit];
      res.has_mask = tbl_has_mask[hit];
      res.mask = tbl_has_mask[hit] ? tbl_mask[hit] : '0;
      if (req.func == ipv4lpm_pkg::FUNC_DELETE) begin
        for (i = hit; i + 1 < tbl_used; i++) begin
          tbl_addr[i] = tbl_addr[i + 1];
          tbl_mask[i] = tbl_mask[i + 1];
          tbl_has_mask[i] = tbl_has_mask[i + 1];
        end
        tbl_used--;
      end
    end
    res.count = ipv4lpm_pkg::COUNT_W'(tbl_used);
    return res;
  endfunction

  function automatic logic [ipv4lpm_pkg::ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 :
           ({ipv4lpm_pkg::ADDR_W{1'b1}} << (ipv4lpm_pkg::ADDR_W - len));
  endfunction

  // Picks an operation at random, starting from the given position in code order.
  function automatic logic [ipv4lpm_pkg::FUNC_W-1:0] pick_operation(input int lo);
    case ($urandom_range(lo, 3))
      0: return ipv4lpm_pkg::FUNC_ADD;
      1: return ipv4lpm_pkg::FUNC_DELETE;
      2: return ipv4lpm_pkg::FUNC_LOOKUP;
      default: return ipv4lpm_pkg::FUNC_MATCH;
    endcase
  endfunction

  // Builds a request that hits the entry held at the given table index.
  function automatic route_req_t request_for_slot(input logic [ipv4lpm_pkg::FUNC_W-1:0] func,
                                                  input int idx);
    route_req_t r;
    r.func = func;
    r.given = tbl_has_mask[idx];
    r.mask = tbl_has_mask[idx] ? tbl_mask[idx] : $urandom;
    if (func == ipv4lpm_pkg::FUNC_MATCH) begin
      r.addr = tbl_addr[idx] ^ ($urandom & ~tbl_mask[idx]);
    end else begin
      r.addr = tbl_addr[idx];
    end
    return r;
  endfunction

  // Mostly well-formed traffic against live entries, with some noise mixed in.
  function automatic route_req_t random_request(input int add_weight);
    route_req_t r;
    int         roll;
    roll = $urandom_range(0, 99);
    r.func = ipv4lpm_pkg::FUNC_ADD;
    r.addr = $urandom;
    r.mask = $urandom;
    r.given = 1'($urandom_range(0, 1));
    if (roll < 8) begin
      r.func = pick_operation(0);
    end else if (roll < 8 + add_weight) begin
      if (tbl_used > 0 && $urandom_range(0, 4) == 0) begin
        r.addr = tbl_addr[$urandom_range(0, tbl_used - 1)];
      end
      if ($urandom_range(0, 3) != 0) begin
        r.mask = prefix_mask($urandom_range(0, 32));
      end
      r.given = ($urandom_range(0, 4) != 0);
    end else if (tbl_used > 0 && $urandom_range(0, 3) != 0) begin
      r = request_for_slot(pick_operation(1), $urandom_range(0, tbl_used - 1));
      if ($urandom_range(0, 9) == 0) begin
        r.given = ~r.given;
      end
      if ($urandom_range(0, 9) == 0) begin
        r.mask[$urandom_range(0, ipv4lpm_pkg::ADDR_W - 1)] ^= 1'b1;
      end
    end else begin
      r.func = pick_operation(1);
    end
    return r;
  endfunction

  // Wait drawn per item: often none, sometimes short, sometimes up to the maximum.
  function automatic int draw_wait(input bit enabled);
    if (!enabled) begin
      return 0;
    end
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(1, 4);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [ipv4lpm_pkg::ADDR_W-1:0] got,
                                 input logic [ipv4lpm_pkg::ADDR_W-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Offers one item, holds it until accepted, then records the expected route.
  task automatic send_item(input route_req_t req);
    int gap;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= req.func;
    in_dest_addr <= req.addr;
    in_dest_mask <= req.mask;
    in_mask_given <= req.given;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_routes.push_back(route_table_apply(req));
  endtask

  task automatic send_op(input logic [ipv4lpm_pkg::FUNC_W-1:0] func,
                         input logic [ipv4lpm_pkg::ADDR_W-1:0] addr,
                         input logic [ipv4lpm_pkg::ADDR_W-1:0] mask, input logic given);
    route_req_t r;
    r.func = func;
    r.addr = addr;
    r.mask = mask;
    r.given = given;
    send_item(r);
  endtask

  // Drops valid and waits until every expected route has come back.
  task automatic stop_input();
    in_valid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
  endtask

  // Empty table, mask rules, ties, unmasked fallback and delete reordering.
  task automatic test_directed();
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'hC0A8_0101, 32'h0000_0000, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'h0A00_0000, 32'hFF00_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'h0A01_0000, 32'hFFFF_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'h0A01_0000, 32'hFFFF_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1);
    // The mask of an unmasked add is ignored and stored as zero.
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'hC0A8_0000, 32'hDEAD_BEEF, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'h0A00_00FF, 32'hFF00_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'h0A01_0203, 32'h0000_0000, 1'b0);
    // Two equal /8 masks match; the older entry must win.
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'h0A02_0304, 32'hFFFF_FFFF, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // A masked default route beats an unmasked entry.
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'h7F00_0001, 32'h0000_0000, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_LOOKUP, 32'hC0A8_0000, 32'h1234_5678, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_LOOKUP, 32'hC0A8_0000, 32'h0000_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_LOOKUP, 32'h0A00_0000, 32'hFFFF_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'h7F00_0001, 32'h0000_0000, 1'b0);
    // With two unmasked entries the newest one is taken.
    send_op(ipv4lpm_pkg::FUNC_ADD,    32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'h7F00_0001, 32'h0000_0000, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_DELETE, 32'h0A01_0000, 32'hFFFF_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_LOOKUP, 32'h0A01_0000, 32'hFFFF_0000, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_DELETE, 32'hC0A8_0000, 32'hFFFF_FFFF, 1'b0);
    send_op(ipv4lpm_pkg::FUNC_MATCH,  32'h5555_5555, 32'h0000_0000, 1'b0);
  endtask

  // Fills the table, adds past the end, then deletes every entry, with a final delete on the empty table.
  task automatic test_table_full();
    while (tbl_used < ipv4lpm_pkg::TABLE_DEPTH) begin
      send_item(random_request(100));
    end
    send_op(ipv4lpm_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(ipv4lpm_pkg::FUNC_ADD, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(request_for_slot(ipv4lpm_pkg::FUNC_MATCH,
                               $urandom_range(0, ipv4lpm_pkg::TABLE_DEPTH - 1)));
    while (tbl_used > 0) begin
      send_item(request_for_slot(ipv4lpm_pkg::FUNC_DELETE, $urandom_range(0, tbl_used - 1)));
    end
    send_op(ipv4lpm_pkg::FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b0);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_long_hold();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    long_hold_cycles = LONG_HOLD;
    repeat (40) send_item(random_request(50));
    stop_input();
  endtask

  // The sender pauses until the table has answered everything.
  task automatic test_pause_drain();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    repeat (15) send_item(random_request(60));
    stop_input();
    repeat (15) send_item(random_request(30));
  endtask

  // Random traffic in blocks, each with its own idling and add/delete balance.
  task automatic test_random();
    int blk;
    int add_weight;
    for (blk = 0; blk < 11; blk++) begin
      in_idle_on = ($urandom_range(0, 2) != 0);
      out_idle_on = ($urandom_range(0, 2) != 0);
      add_weight = (blk % 2 == 0) ? $urandom_range(45, 70) : $urandom_range(10, 30);
      repeat (90) send_item(random_request(add_weight));
      if ($urandom_range(0, 2) == 0) begin
        stop_input();
      end
    end
  endtask

  // Result receiver: draws a stall per item, or takes a long hold when asked.
  initial begin : result_receiver
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        hold = draw_wait(out_idle_on);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  // Compare each accepted result with the oldest expected route.
  always @(posedge clk) begin : route_checker
    route_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_routes.size() == 0) begin
        report_mismatch("unexpected item, route_addr", out_route_addr, '0);
      end else begin
        want = expected_routes.pop_front();
        if (out_found !== want.found) begin
          report_mismatch("found", ipv4lpm_pkg::ADDR_W'(out_found),
                          ipv4lpm_pkg::ADDR_W'(want.found));
        end
        if (out_route_addr !== want.addr) begin
          report_mismatch("route_addr", out_route_addr, want.addr);
        end
        if (out_route_mask !== want.mask) begin
          report_mismatch("route_mask", out_route_mask, want.mask);
        end
        if (out_route_has_mask !== want.has_mask) begin
          report_mismatch("route_has_mask", ipv4lpm_pkg::ADDR_W'(out_route_has_mask),
                          ipv4lpm_pkg::ADDR_W'(want.has_mask));
        end
        if (out_entry_count !== want.count) begin
          report_mismatch("entry_count", ipv4lpm_pkg::ADDR_W'(out_entry_count),
                          ipv4lpm_pkg::ADDR_W'(want.count));
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_long_hold();
    test_pause_drain();
    test_random();
    stop_input();
    repeat (ipv4lpm_pkg::TABLE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
